// ----- hw/rtl/pla_pkg.sv -----
// pla_pkg: shared types, constants and arithmetic helpers for the phong light accumulator
// no dependencies
`default_nettype none

package pla_pkg;

   localparam int unsigned AccWidth  = 20;
   localparam int unsigned ProdWidth = 42;
   localparam int unsigned RndWidth  = 27;

   localparam logic [AccWidth-1:0] ACC_MAX   = 20'hFFFFF;
   localparam logic [15:0]         ONE_Q15   = 16'd32768;
   localparam logic [16:0]         EXP_LIMIT = 17'd100000;

   // configuration register byte addresses
   localparam logic [2:0] REG_SHADOW_FACTOR = 3'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AMB,
      ST_NL,
      ST_RL,
      ST_POW,
      ST_SPF,
      ST_SPEC,
      ST_NLF,
      ST_DC,
      ST_DIF,
      ST_DONE
   } pla_state_type;

   // round a non-negative Q.30 product to Q.15
   function automatic logic [RndWidth-1:0] rnd_q15(input logic [ProdWidth-1:0] p);
      logic [ProdWidth:0] s;
      s = {1'b0, p} + (ProdWidth+1)'(16384);
      return s[ProdWidth-1:15];
   endfunction

   // saturating accumulator add
   function automatic logic [AccWidth-1:0] sat_acc(input logic [AccWidth-1:0] a,
                                                   input logic [RndWidth-1:0] b);
      logic [RndWidth:0] s;
      s = {8'b0, a} + {1'b0, b};
      return (s > {8'b0, ACC_MAX}) ? ACC_MAX : s[AccWidth-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pla_req_if.sv -----
// pla_req_if: input channel of the phong light accumulator, one light sample per transaction
// no dependencies
`default_nettype none

interface pla_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] surface_normal;
   logic [47:0] light_dir;
   logic [47:0] reflect_dir;
   logic [47:0] light_color;
   logic [47:0] diffuse_color;
   logic [16:0] specular_exponent;
   logic [15:0] light_fraction;
   logic        obscured;
   logic        first_light;

   modport source (output valid, surface_normal, light_dir, reflect_dir, light_color,
                   diffuse_color, specular_exponent, light_fraction, obscured, first_light,
                   input ready);
   modport sink (input valid, surface_normal, light_dir, reflect_dir, light_color,
                 diffuse_color, specular_exponent, light_fraction, obscured, first_light,
                 output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pla_rsp_if.sv -----
// pla_rsp_if: result channel of the phong light accumulator, nine saturating sums
// no dependencies
`default_nettype none

interface pla_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] ambient_red;
   logic [19:0] ambient_green;
   logic [19:0] ambient_blue;
   logic [19:0] diffuse_red;
   logic [19:0] diffuse_green;
   logic [19:0] diffuse_blue;
   logic [19:0] specular_red;
   logic [19:0] specular_green;
   logic [19:0] specular_blue;

   modport source (output valid, ambient_red, ambient_green, ambient_blue, diffuse_red,
                   diffuse_green, diffuse_blue, specular_red, specular_green, specular_blue,
                   input ready);
   modport sink (input valid, ambient_red, ambient_green, ambient_blue, diffuse_red,
                 diffuse_green, diffuse_blue, specular_red, specular_green, specular_blue,
                 output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/phong_light_accumulator.sv -----
// phong_light_accumulator: top level, sequencer around one shared 21x21 signed multiplier
// depends on pla_pkg, pla_req_if, pla_rsp_if
`default_nettype none

// One light sample is taken per req transaction and folded into three saturating
// RGB sums (ambient, diffuse, specular); each sample yields one rsp transaction with
// all nine sums after the update. first_light clears the sums before the sample adds.
// All products go through a single shared multiplier, and every multiply has two phases
// (issue, then round and use); an obscured light finishes soonest, while a large
// specular exponent costs two multiplies per exponent bit in the square-and-multiply
// loop. The power loop stops at the exponent's top set bit,
// so small exponents finish much sooner. req.ready is high only while the sequencer is
// idle; a finished result sits in its own output register, so the next sample can be
// accepted while the previous result waits. shadow_factor is written through the APB
// port at byte address 0 and must only change while the block is idle.
module phong_light_accumulator
   import pla_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   pla_req_if.sink     req,
   pla_rsp_if.source   rsp,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // sequencer state
   pla_state_type state_ff, state_in;
   logic          phase_ff, phase_in;   // 0 = issue multiply, 1 = use product
   logic [1:0]    idx_ff, idx_in;       // color channel or vector component
   logic          sq_ff, sq_in;         // power loop: 0 = multiply result, 1 = square
   logic          load_out;

   // captured transaction
   logic [47:0] nrm_ff, ldr_ff, rdr_ff, lcol_ff, dcol_ff;
   logic [16:0] exp_ff;
   logic [15:0] frac_ff;
   logic        obs_ff;

   // configuration
   logic [15:0] sf_ff;

   // accumulators and result register
   logic [AccWidth-1:0] amb_ff [3];
   logic [AccWidth-1:0] dif_ff [3];
   logic [AccWidth-1:0] spc_ff [3];
   logic [AccWidth-1:0] oamb_ff [3];
   logic [AccWidth-1:0] odif_ff [3];
   logic [AccWidth-1:0] ospc_ff [3];
   logic                rsp_valid_ff;

   // working registers
   logic signed [ProdWidth-1:0] prod_ff;
   logic signed [33:0]          dot_ff;
   logic [18:0]                 nl_ff;
   logic [15:0]                 base_ff;
   logic [15:0]                 pow_ff;
   logic [19:0]                 fac_ff;
   logic [16:0]                 dc_ff;

   // shared multiplier operands
   logic signed [20:0] mul_a, mul_b;
   logic [15:0]        n_c, l_c, r_c, lc_c, dc_c;
   logic [RndWidth-1:0] rnd;
   logic signed [33:0] dot_sum;
   logic signed [33:0] t_val;
   logic [19:0]        t_q;
   logic [15:0]        base_val;
   logic               req_fire;
   logic               csr_wr;

   assign req_fire = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // component selects for the current channel
   assign n_c  = nrm_ff[{idx_ff, 4'b0} +: 16];
   assign l_c  = ldr_ff[{idx_ff, 4'b0} +: 16];
   assign r_c  = rdr_ff[{idx_ff, 4'b0} +: 16];
   assign lc_c = lcol_ff[{idx_ff, 4'b0} +: 16];
   assign dc_c = dcol_ff[{idx_ff, 4'b0} +: 16];

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_AMB: begin
            mul_a = {5'b0, dc_c};
            mul_b = {5'b0, sf_ff};
         end
         ST_NL: begin
            mul_a = {{5{n_c[15]}}, n_c};
            mul_b = {{5{l_c[15]}}, l_c};
         end
         ST_RL: begin
            mul_a = {{5{r_c[15]}}, r_c};
            mul_b = {{5{l_c[15]}}, l_c};
         end
         ST_POW: begin
            mul_a = sq_ff ? {5'b0, base_ff} : {5'b0, pow_ff};
            mul_b = {5'b0, base_ff};
         end
         ST_SPF: begin
            mul_a = {5'b0, pow_ff};
            mul_b = {5'b0, frac_ff};
         end
         ST_SPEC: begin
            mul_a = {5'b0, lc_c};
            mul_b = {1'b0, fac_ff};
         end
         ST_NLF: begin
            mul_a = {2'b0, nl_ff};
            mul_b = {5'b0, frac_ff};
         end
         ST_DC: begin
            mul_a = {5'b0, dc_c};
            mul_b = {5'b0, lc_c};
         end
         ST_DIF: begin
            mul_a = {4'b0, dc_ff};
            mul_b = {1'b0, fac_ff};
         end
         ST_IDLE, ST_DONE: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // product post-processing
   assign rnd     = rnd_q15(ProdWidth'(prod_ff));
   assign dot_sum = ((idx_ff == 2'd0) ? 34'sd0 : dot_ff) + $signed(prod_ff[33:0]);
   assign t_val   = dot_sum + 34'sd268435456;
   assign t_q     = t_val[33:14];
   always_comb begin
      if (t_val <= 34'sd0) begin
         base_val = '0;
      end else if (t_q > {4'b0, ONE_Q15}) begin
         base_val = ONE_Q15;
      end else begin
         base_val = t_q[15:0];
      end
   end

   // sequencer: next state and control
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      sq_in    = sq_ff;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            phase_in = 1'b0;
            idx_in   = 2'd0;
            if (req_fire) begin
               state_in = ST_AMB;
            end
         end
         ST_DONE: begin
            phase_in = 1'b0;
            if (!rsp_valid_ff || rsp.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            phase_in = ~phase_ff;
            if (phase_ff) begin
               priority case (state_ff)
                  ST_AMB: begin
                     if (idx_ff != 2'd2) begin
                        idx_in = idx_ff + 2'd1;
                     end else begin
                        idx_in   = 2'd0;
                        state_in = obs_ff ? ST_DONE : ST_NL;
                     end
                  end
                  ST_NL: begin
                     if (idx_ff != 2'd2) begin
                        idx_in = idx_ff + 2'd1;
                     end else begin
                        idx_in = 2'd0;
                        priority if (dot_sum < 34'sd0) begin
                           state_in = ST_DONE;
                        end else if (exp_ff >= EXP_LIMIT) begin
                           state_in = ST_NLF;
                        end else begin
                           state_in = ST_RL;
                        end
                     end
                  end
                  ST_RL: begin
                     if (idx_ff != 2'd2) begin
                        idx_in = idx_ff + 2'd1;
                     end else begin
                        idx_in   = 2'd0;
                        sq_in    = 1'b0;
                        state_in = (exp_ff == '0) ? ST_SPF : ST_POW;
                     end
                  end
                  ST_POW: begin
                     sq_in = ~sq_ff;
                     if (sq_ff && exp_ff[16:1] == '0) begin
                        state_in = ST_SPF;
                     end
                  end
                  ST_SPF: begin
                     idx_in   = 2'd0;
                     state_in = ST_SPEC;
                  end
                  ST_SPEC: begin
                     if (idx_ff != 2'd2) begin
                        idx_in = idx_ff + 2'd1;
                     end else begin
                        idx_in   = 2'd0;
                        state_in = ST_NLF;
                     end
                  end
                  ST_NLF: begin
                     idx_in   = 2'd0;
                     state_in = (rnd > {11'b0, sf_ff}) ? ST_DC : ST_DONE;
                  end
                  ST_DC: begin
                     state_in = ST_DIF;
                  end
                  ST_DIF: begin
                     if (idx_ff != 2'd2) begin
                        idx_in   = idx_ff + 2'd1;
                        state_in = ST_DC;
                     end else begin
                        idx_in   = 2'd0;
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         idx_ff   <= 2'd0;
         sq_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         sq_ff    <= sq_in;
      end
   end

   // shared multiplier, product always registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // capture of the incoming transaction and working datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         nrm_ff  <= req.surface_normal;
         ldr_ff  <= req.light_dir;
         rdr_ff  <= req.reflect_dir;
         lcol_ff <= req.light_color;
         dcol_ff <= req.diffuse_color;
         exp_ff  <= req.specular_exponent;
         frac_ff <= req.light_fraction;
         obs_ff  <= req.obscured;
      end
      if (phase_ff) begin
         unique case (state_ff)
            ST_NL: begin
               dot_ff <= dot_sum;
               nl_ff  <= dot_sum[31:13];
            end
            ST_RL: begin
               dot_ff  <= dot_sum;
               base_ff <= base_val;
               pow_ff  <= ONE_Q15;
            end
            ST_POW: begin
               if (sq_ff) begin
                  base_ff <= rnd[15:0];
                  exp_ff  <= {1'b0, exp_ff[16:1]};
               end else if (exp_ff[0]) begin
                  pow_ff <= rnd[15:0];
               end
            end
            ST_SPF: begin
               fac_ff <= rnd[19:0];
            end
            ST_NLF: begin
               fac_ff <= rnd[19:0] - {4'b0, sf_ff};
            end
            ST_DC: begin
               dc_ff <= rnd[16:0];
            end
            ST_IDLE, ST_AMB, ST_SPEC, ST_DIF, ST_DONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   // accumulators: first_light clears at accept, each term adds on its use cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            amb_ff[i] <= '0;
            dif_ff[i] <= '0;
            spc_ff[i] <= '0;
         end
      end else if (req_fire && req.first_light) begin
         for (int i = 0; i < 3; i++) begin
            amb_ff[i] <= '0;
            dif_ff[i] <= '0;
            spc_ff[i] <= '0;
         end
      end else if (phase_ff) begin
         if (state_ff == ST_AMB) begin
            amb_ff[idx_ff] <= sat_acc(amb_ff[idx_ff], rnd);
         end
         if (state_ff == ST_SPEC) begin
            spc_ff[idx_ff] <= sat_acc(spc_ff[idx_ff], rnd);
         end
         if (state_ff == ST_DIF) begin
            dif_ff[idx_ff] <= sat_acc(dif_ff[idx_ff], rnd);
         end
      end
   end

   // result register, decoupled from the accumulators
   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int i = 0; i < 3; i++) begin
            oamb_ff[i] <= amb_ff[i];
            odif_ff[i] <= dif_ff[i];
            ospc_ff[i] <= spc_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.ambient_red    = oamb_ff[0];
   assign rsp.ambient_green  = oamb_ff[1];
   assign rsp.ambient_blue   = oamb_ff[2];
   assign rsp.diffuse_red    = odif_ff[0];
   assign rsp.diffuse_green  = odif_ff[1];
   assign rsp.diffuse_blue   = odif_ff[2];
   assign rsp.specular_red   = ospc_ff[0];
   assign rsp.specular_green = ospc_ff[1];
   assign rsp.specular_blue  = ospc_ff[2];

   // apb configuration port, single shadow_factor register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff <= '0;
      end else if (csr_wr && paddr == REG_SHADOW_FACTOR) begin
         sf_ff <= pwdata[15:0];
      end
   end

   assign prdata = (paddr == REG_SHADOW_FACTOR) ? {16'b0, sf_ff} : 32'b0;

`ifndef SYNTHESIS
   // a transaction is accepted only by an idle sequencer, never two in a row
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req.ready)
      else $error("accepted two transactions back to back");

   // power operands stay within 1.0 during the power loop
   a_pow_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POW |-> (base_ff <= ONE_Q15) && (pow_ff <= ONE_Q15))
      else $error("power operand above 1.0");

   // a result is only published from the done state
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result published outside done state");
`endif

endmodule

`default_nettype wire
